/* sv/qrim_pkg.sv */
`timescale 1ns / 1ps
package qrim_pkg;

  localparam int CB      = 12;          // coordinate bits
  localparam int DW      = CB + 2;      // pixel minus corner, signed
  localparam int EW      = CB + 1;      // corner minus corner, signed
  localparam int PW      = DW + EW;     // one product of a cross term
  localparam int NW      = PW + 1;      // edge cross product, signed
  localparam int DENW    = NW + 1;      // interpolation denominator, unsigned
  localparam int PRODW   = CB + NW;     // interpolation numerator, unsigned
  localparam int SW      = CB + 1;      // source width / height
  localparam int CFGW    = 2 * CB + 2;  // widest config register
  localparam int IDXW    = 3;
  localparam int LAT     = CB + 5;      // accept to result strobe

  localparam logic [IDXW-1:0] REG_CORNER_A = 3'd0;
  localparam logic [IDXW-1:0] REG_CORNER_B = 3'd1;
  localparam logic [IDXW-1:0] REG_CORNER_C = 3'd2;
  localparam logic [IDXW-1:0] REG_CORNER_D = 3'd3;
  localparam logic [IDXW-1:0] REG_SPAN_X   = 3'd4;
  localparam logic [IDXW-1:0] REG_SPAN_Y   = 3'd5;
  localparam logic [IDXW-1:0] REG_SIZE     = 3'd6;

  typedef struct packed {
    logic [CB-1:0] quo;
    logic          rem_nz;
  } div_res_t;

endpackage

/* sv/quad_to_rect_inverse_map.sv */
`timescale 1ns / 1ps
// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------
// input    | start, busy            | in_pixel_x, in_pixel_y
// result   | out_valid (strobe)     | out_hit, out_echo_x/y, out_texel_u/v
// config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// one item per clock; busy stays low and cfg_ready stays high
// 17 registers from input to result: input register, two cross product stages,
// one interpolation multiply stage, a 12-stage divider (one quotient bit per
// stage), one output stage
// synchronous active-low reset clears the valid bits and the config registers
// the result side cannot stall, so the pipeline never holds
module quad_to_rect_inverse_map (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [qrim_pkg::CB-1:0]     in_pixel_x,
  input  logic [qrim_pkg::CB-1:0]     in_pixel_y,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [qrim_pkg::CB-1:0]     out_echo_x,
  output logic [qrim_pkg::CB-1:0]     out_echo_y,
  output logic [qrim_pkg::CB-1:0]     out_texel_u,
  output logic [qrim_pkg::CB-1:0]     out_texel_v,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [qrim_pkg::IDXW-1:0]   cfg_index,
  input  logic [qrim_pkg::CFGW-1:0]   cfg_data
);
  import qrim_pkg::*;

  typedef struct packed {
    logic          vld;
    logic          ok;
    logic [CB-1:0] px;
    logic [CB-1:0] py;
    logic          neg_u;
    logic          neg_v;
    logic [CB-1:0] x0;
    logic [CB-1:0] y0;
  } side_t;

  // config
  logic [2*CB-1:0] cor_r [4];
  logic [2*CB-1:0] span_x_r, span_y_r;
  logic [CFGW-1:0] size_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) cor_r[i] <= '0;
      span_x_r <= '0;
      span_y_r <= '0;
      size_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CORNER_A: cor_r[0] <= cfg_data[2*CB-1:0];
        REG_CORNER_B: cor_r[1] <= cfg_data[2*CB-1:0];
        REG_CORNER_C: cor_r[2] <= cfg_data[2*CB-1:0];
        REG_CORNER_D: cor_r[3] <= cfg_data[2*CB-1:0];
        REG_SPAN_X:   span_x_r <= cfg_data[2*CB-1:0];
        REG_SPAN_Y:   span_y_r <= cfg_data[2*CB-1:0];
        REG_SIZE:     size_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: input register
  logic          s0_vld_r;
  logic [CB-1:0] s0_px_r, s0_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else        s0_vld_r <= start && !busy;
    s0_px_r <= in_pixel_x;
    s0_py_r <= in_pixel_y;
  end

  // stage 1: cross product terms, edge e runs corner e to corner e+1
  logic signed [DW-1:0] dx [4], dy [4];
  logic signed [EW-1:0] ex [4], ey [4];
  logic signed [PW-1:0] m1_r [4], m2_r [4];
  logic                 s1_vld_r;
  logic [CB-1:0]        s1_px_r, s1_py_r;

  always_comb begin
    for (int e = 0; e < 4; e++) begin
      dx[e] = $signed({2'b00, s0_px_r})
            - $signed({{2{cor_r[e][CB-1]}}, cor_r[e][CB-1:0]});
      dy[e] = $signed({2'b00, s0_py_r})
            - $signed({{2{cor_r[e][2*CB-1]}}, cor_r[e][2*CB-1:CB]});
      ex[e] = $signed({cor_r[(e+1)%4][CB-1], cor_r[(e+1)%4][CB-1:0]})
            - $signed({cor_r[e][CB-1], cor_r[e][CB-1:0]});
      ey[e] = $signed({cor_r[(e+1)%4][2*CB-1], cor_r[(e+1)%4][2*CB-1:CB]})
            - $signed({cor_r[e][2*CB-1], cor_r[e][2*CB-1:CB]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= s0_vld_r;
    s1_px_r <= s0_px_r;
    s1_py_r <= s0_py_r;
    for (int e = 0; e < 4; e++) begin
      m1_r[e] <= PW'(dx[e] * ey[e]);
      m2_r[e] <= PW'(dy[e] * ex[e]);
    end
  end

  // stage 2: edge functions nab, nbc, ncd, nda
  logic signed [NW-1:0] n_r [4];
  logic                 s2_vld_r;
  logic [CB-1:0]        s2_px_r, s2_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    s2_px_r <= s1_px_r;
    s2_py_r <= s1_py_r;
    for (int e = 0; e < 4; e++)
      n_r[e] <= NW'(m1_r[e]) - NW'(m2_r[e]);
  end

  // stage 3: inside test, denominators, interpolation numerators
  logic                  in_quad;
  logic signed [NW:0]    sum_u, sum_v;
  logic [DENW-1:0]       den_u, den_v;
  logic [NW-1:0]         mag_u, mag_v;
  logic [CB-1:0]         x0, x1, y0, y1, span_u, span_v;
  logic                  neg_u, neg_v;
  logic [PRODW-1:0]      num_u_r, num_v_r;
  logic [DENW-1:0]       den_u_r, den_v_r;
  side_t                 s3_r;

  always_comb begin
    in_quad = 1'b1;
    for (int e = 0; e < 4; e++)
      if (!(n_r[e][NW-1] || n_r[e] == '0)) in_quad = 1'b0;
    sum_u = $signed({n_r[3][NW-1], n_r[3]}) + $signed({n_r[1][NW-1], n_r[1]});
    sum_v = $signed({n_r[0][NW-1], n_r[0]}) + $signed({n_r[2][NW-1], n_r[2]});
    den_u = DENW'(-sum_u);
    den_v = DENW'(-sum_v);
    mag_u = NW'(-n_r[3]);
    mag_v = NW'(-n_r[0]);
    x0 = span_x_r[CB-1:0];
    x1 = span_x_r[2*CB-1:CB];
    y0 = span_y_r[CB-1:0];
    y1 = span_y_r[2*CB-1:CB];
    neg_u  = x1 < x0;
    neg_v  = y1 < y0;
    span_u = neg_u ? x0 - x1 : x1 - x0;
    span_v = neg_v ? y0 - y1 : y1 - y0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_r.vld <= 1'b0;
    else        s3_r.vld <= s2_vld_r;
    s3_r.ok    <= in_quad && den_u != '0 && den_v != '0;
    s3_r.px    <= s2_px_r;
    s3_r.py    <= s2_py_r;
    s3_r.neg_u <= neg_u;
    s3_r.neg_v <= neg_v;
    s3_r.x0    <= x0;
    s3_r.y0    <= y0;
    num_u_r    <= PRODW'(span_u * mag_u);
    num_v_r    <= PRODW'(span_v * mag_v);
    den_u_r    <= den_u;
    den_v_r    <= den_v;
  end

  // divider stages, side info travels alongside
  div_res_t res_u, res_v;
  side_t    side_r [CB];
  side_t    side_nxt [CB];

  qrim_div u_div_u (.clk(clk), .num(num_u_r), .den(den_u_r), .res(res_u));
  qrim_div u_div_v (.clk(clk), .num(num_v_r), .den(den_v_r), .res(res_v));

  always_comb begin
    side_nxt[0] = s3_r;
    for (int k = 1; k < CB; k++) side_nxt[k] = side_r[k-1];
    for (int k = 0; k < CB; k++)
      if (!rst_n) side_nxt[k].vld = 1'b0;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CB; k++) side_r[k] <= side_nxt[k];
  end

  // final stage: floor toward minus infinity, range check
  side_t                side;
  logic [CB:0]          q_u, q_v;
  logic signed [CB+1:0] u, v;
  logic [SW-1:0]        src_w, src_h;
  logic                 hit_nxt;

  always_comb begin
    side  = side_r[CB-1];
    src_w = size_r[SW-1:0];
    src_h = size_r[2*SW-1:SW];
    q_u = {1'b0, res_u.quo} + (CB+1)'(side.neg_u && res_u.rem_nz);
    q_v = {1'b0, res_v.quo} + (CB+1)'(side.neg_v && res_v.rem_nz);
    u = side.neg_u ? $signed({2'b00, side.x0}) - $signed({1'b0, q_u})
                   : $signed({2'b00, side.x0}) + $signed({1'b0, q_u});
    v = side.neg_v ? $signed({2'b00, side.y0}) - $signed({1'b0, q_v})
                   : $signed({2'b00, side.y0}) + $signed({1'b0, q_v});
    hit_nxt = side.vld && side.ok
           && !u[CB+1] && ({1'b0, u[CB:0]} < {1'b0, src_w})
           && !v[CB+1] && ({1'b0, v[CB:0]} < {1'b0, src_h});
  end

  logic          out_valid_r, out_hit_r;
  logic [CB-1:0] out_x_r, out_y_r, out_u_r, out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
    end else begin
      out_valid_r <= side.vld;
      out_hit_r   <= hit_nxt;
    end
    out_x_r <= side.px;
    out_y_r <= side.py;
    out_u_r <= hit_nxt ? u[CB-1:0] : '0;
    out_v_r <= hit_nxt ? v[CB-1:0] : '0;
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_echo_x  = out_x_r;
  assign out_echo_y  = out_y_r;
  assign out_texel_u = out_u_r;
  assign out_texel_v = out_v_r;

endmodule

/* sv/qrim_div.sv */
`timescale 1ns / 1ps
module qrim_div (
  input  logic                    clk,
  input  logic [qrim_pkg::PRODW-1:0] num,
  input  logic [qrim_pkg::DENW-1:0]  den,
  output qrim_pkg::div_res_t      res
);
  import qrim_pkg::*;

  // restoring divider, one quotient bit per stage; quotient known to fit CB bits
  logic [DENW-1:0] rem_r [CB];
  logic [CB-1:0]   low_r [CB];
  logic [CB-1:0]   quo_r [CB];
  logic [DENW-1:0] den_r [CB];

  logic [DENW-1:0] rem_in [CB];
  logic [CB-1:0]   low_in [CB];
  logic [CB-1:0]   quo_in [CB];
  logic [DENW-1:0] den_in [CB];
  logic [DENW-1:0] rem_nxt [CB];
  logic [CB-1:0]   low_nxt [CB];
  logic [CB-1:0]   quo_nxt [CB];

  always_comb begin
    rem_in[0] = {1'b0, num[PRODW-1:CB]};
    low_in[0] = num[CB-1:0];
    quo_in[0] = '0;
    den_in[0] = den;
    for (int k = 1; k < CB; k++) begin
      rem_in[k] = rem_r[k-1];
      low_in[k] = low_r[k-1];
      quo_in[k] = quo_r[k-1];
      den_in[k] = den_r[k-1];
    end
  end

  for (genvar k = 0; k < CB; k++) begin : g_stage
    logic [DENW:0] trial;
    logic [DENW:0] diff;
    always_comb begin
      trial = {rem_in[k], low_in[k][CB-1]};
      diff  = trial - {1'b0, den_in[k]};
      if (trial >= {1'b0, den_in[k]}) begin
        rem_nxt[k] = diff[DENW-1:0];
        quo_nxt[k] = {quo_in[k][CB-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[DENW-1:0];
        quo_nxt[k] = {quo_in[k][CB-2:0], 1'b0};
      end
      low_nxt[k] = {low_in[k][CB-2:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt[k];
      low_r[k] <= low_nxt[k];
      quo_r[k] <= quo_nxt[k];
      den_r[k] <= den_in[k];
    end
  end

  assign res.quo    = quo_r[CB-1];
  assign res.rem_nz = (rem_r[CB-1] != '0);

endmodule

/* sv/qrim_chk.sv */
`timescale 1ns / 1ps
module qrim_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic [qrim_pkg::CB-1:0] in_pixel_x,
  input logic [qrim_pkg::CB-1:0] in_pixel_y,
  input logic                    out_valid,
  input logic                    out_hit,
  input logic [qrim_pkg::CB-1:0] out_echo_x,
  input logic [qrim_pkg::CB-1:0] out_echo_y,
  input logic [qrim_pkg::CB-1:0] out_texel_u,
  input logic [qrim_pkg::CB-1:0] out_texel_v
);
  import qrim_pkg::*;

  // every result traces back to an item accepted a fixed latency earlier
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching item");

  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_echo_x == $past(in_pixel_x, LAT)
                && out_echo_y == $past(in_pixel_y, LAT)))
    else $error("echoed pixel mismatch");

  a_hit_vld: assert property (@(posedge clk) disable iff (!rst_n)
    out_hit |-> out_valid)
    else $error("hit without strobe");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_texel_u == '0 && out_texel_v == '0))
    else $error("texel not zero on miss");

endmodule

bind quad_to_rect_inverse_map qrim_chk u_qrim_chk (.*);
